FILE: hdl/mrrc_pkg.sv
// shared types and constants for the modbus rtu response checker
package mrrc_pkg;

    localparam int RX_BUFFER_BYTES = 256;
    localparam int MAX_RESULTS     = 32;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CRC_ERROR   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT     = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [1:0] REG_SLAVE_ADDRESS     = 2'd0;
    localparam logic [1:0] REG_EXPECTED_FUNCTION = 2'd1;
    localparam logic [1:0] REG_HEADER_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_BODY_TIMEOUT      = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CRC,
        SEQ_RESULT,
        SEQ_EMIT_RD,
        SEQ_EMIT_PUT
    } seq_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] data_word;
        logic [5:0]  word_index;
        logic [7:0]  word_count;
        logic        last;
    } out_item_t;

endpackage

FILE: hdl/modbus_rtu_response_checker.sv
// modbus rtu reply checker: header match, timeouts, bitwise crc and word unpacking
//
// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  in_item_t  (func, rx_byte)
// m_       out        m_valid / m_ready  out_item_t (status, data_word, word_index, ...)
// cfg_     in         cfg_we             cfg_index, cfg_data
//
// a byte that enters the crc is accepted, then runs bit by bit through the
// single-bit crc shifter; ticks, start beats and unchecked bytes bypass the shifter.
// each emitted word is read from the store, then put in the output register; m_ready stalls can hold it.
// s_ready is low while the crc shifter runs or results are being emitted.
// reset is synchronous on aresetn; the word store needs no clearing.
module modbus_rtu_response_checker
    import mrrc_pkg::*;
#(
    parameter int WORD_CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (WORD_CAPACITY > 1) ? $clog2(WORD_CAPACITY) : 1;
    localparam logic [6:0] CAP = 7'(WORD_CAPACITY);
    localparam logic [9:0] RX_LIMIT = 10'(RX_BUFFER_BYTES);

    logic [7:0]  sa_reg;
    logic [4:0]  ef_reg;
    logic [15:0] ht_reg, bt_reg;

    phase_t      phase_reg, phase_next;
    seq_t        seq_reg, seq_next;
    logic [8:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  bc_reg, bc_next;
    logic [7:0]  held_reg, held_next;
    logic [6:0]  stored_reg, stored_next;
    logic [15:0] tick_reg, tick_next;
    logic        mism_reg, mism_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [2:0]  bit_reg, bit_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  n_reg, n_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [2:0]  pst_reg, pst_next;
    logic        mv_reg, mv_next;
    out_item_t   out_reg, out_next;

    logic [15:0] mem [WORD_CAPACITY];
    logic [15:0] rdata_reg;
    logic        we;
    logic [AW-1:0] waddr;
    logic [15:0] wdata;

    logic        fn_ok, rd, coil, out_free;
    logic [7:0]  b, bc_eff;
    logic [8:0]  p, crc_len, d;
    logic [9:0]  total, p1;
    logic [6:0]  idx;
    logic [6:0]  n_full;

    assign s_ready  = (seq_reg == SEQ_IDLE);
    assign m_valid  = mv_reg;
    assign m_data   = out_reg;
    assign out_free = !mv_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_reg <= 8'd1;
            ef_reg <= 5'd3;
            ht_reg <= 16'd100;
            bt_reg <= 16'd100;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS:     sa_reg <= cfg_data[7:0];
                REG_EXPECTED_FUNCTION: ef_reg <= cfg_data[4:0];
                REG_HEADER_TIMEOUT:    ht_reg <= cfg_data;
                REG_BODY_TIMEOUT:      bt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            seq_reg    <= SEQ_IDLE;
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            bc_reg     <= '0;
            held_reg   <= '0;
            stored_reg <= '0;
            tick_reg   <= '0;
            mism_reg   <= 1'b0;
            fcrc_reg   <= '0;
            bit_reg    <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            pst_reg    <= ST_OK;
            mv_reg     <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            bc_reg     <= bc_next;
            held_reg   <= held_next;
            stored_reg <= stored_next;
            tick_reg   <= tick_next;
            mism_reg   <= mism_next;
            fcrc_reg   <= fcrc_next;
            bit_reg    <= bit_next;
            k_reg      <= k_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
            pst_reg    <= pst_next;
            mv_reg     <= mv_next;
        end
        out_reg <= out_next;
    end

    always_comb begin
        fn_ok = (ef_reg >= 5'd1 && ef_reg <= 5'd6) || ef_reg == 5'd15 || ef_reg == 5'd16;
        rd    = (ef_reg >= 5'd1 && ef_reg <= 5'd4);
        coil  = (ef_reg <= 5'd2);
        b     = s_data.rx_byte;
        p     = pos_reg;
        bc_eff  = (rd && p == 9'd2) ? b : bc_reg;
        crc_len = rd ? (9'd3 + {1'b0, bc_eff}) : 9'd6;
        total   = {1'b0, crc_len} + 10'd2;
        p1      = {1'b0, p} + 10'd1;
        d       = p - 9'd3;
        idx     = d[7:1];

        phase_next  = phase_reg;
        seq_next    = seq_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        bc_next     = bc_reg;
        held_next   = held_reg;
        stored_next = stored_reg;
        tick_next   = tick_reg;
        mism_next   = mism_reg;
        fcrc_next   = fcrc_reg;
        bit_next    = bit_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        pst_next    = pst_reg;
        mv_next     = mv_reg && !m_ready;
        out_next    = out_reg;
        we          = 1'b0;
        waddr       = idx[AW-1:0];
        wdata       = '0;
        n_full      = '0;

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    if (s_data.func == FUNC_START) begin
                        pos_next    = '0;
                        crc_next    = CRC_INIT;
                        bc_next     = '0;
                        held_next   = '0;
                        stored_next = '0;
                        tick_next   = '0;
                        mism_next   = 1'b0;
                        fcrc_next   = '0;
                        if (!fn_ok) begin
                            phase_next = PH_IDLE;
                            pst_next   = ST_UNSUPPORTED;
                            cnt_next   = '0;
                            seq_next   = SEQ_RESULT;
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end else if ((s_data.func == FUNC_BYTE || s_data.func == FUNC_TICK)
                                 && phase_reg != PH_IDLE) begin
                        if (!fn_ok) begin
                            phase_next = PH_IDLE;
                            pst_next   = ST_UNSUPPORTED;
                            cnt_next   = '0;
                            seq_next   = SEQ_RESULT;
                        end else if (s_data.func == FUNC_TICK) begin
                            if ((phase_reg == PH_HEADER && tick_reg >= ht_reg) ||
                                (phase_reg == PH_BODY &&
                                 (tick_reg > bt_reg || tick_reg == 16'hFFFF))) begin
                                phase_next = PH_IDLE;
                                pst_next   = ST_TIMEOUT;
                                cnt_next   = '0;
                                seq_next   = SEQ_RESULT;
                            end else begin
                                tick_next = tick_reg + 16'd1;
                            end
                        end else if (phase_reg == PH_HEADER) begin
                            if (!mism_reg) begin
                                if (p == 9'd0) begin
                                    if (b != sa_reg) begin
                                        mism_next = 1'b1;
                                    end else begin
                                        crc_next = crc_reg ^ {8'd0, b};
                                        bit_next = '0;
                                        seq_next = SEQ_CRC;
                                        pos_next = 9'd1;
                                    end
                                end else if (b != {3'd0, ef_reg}) begin
                                    mism_next = 1'b1;
                                end else begin
                                    crc_next   = crc_reg ^ {8'd0, b};
                                    bit_next   = '0;
                                    seq_next   = SEQ_CRC;
                                    pos_next   = 9'd2;
                                    phase_next = PH_BODY;
                                    tick_next  = '0;
                                end
                            end
                        end else begin
                            // body byte
                            if (rd && p == 9'd2) begin
                                bc_next = b;
                            end
                            if (rd && p == 9'd2 && ({2'd0, b} + 10'd5) > RX_LIMIT) begin
                                phase_next = PH_IDLE;
                                pst_next   = ST_BAD_LENGTH;
                                cnt_next   = '0;
                                seq_next   = SEQ_RESULT;
                            end else begin
                                if (p < crc_len) begin
                                    crc_next = crc_reg ^ {8'd0, b};
                                    bit_next = '0;
                                    seq_next = SEQ_CRC;
                                end
                                if (rd && p >= 9'd3 && p < crc_len) begin
                                    if (!d[0]) begin
                                        held_next = b;
                                        if (coil && ({1'b0, d[7:0]} + 9'd1) == {1'b0, bc_eff}) begin
                                            wdata = {8'd0, b};
                                            we    = (idx < CAP);
                                        end
                                    end else begin
                                        wdata = coil ? {b, held_reg} : {held_reg, b};
                                        we    = (idx < CAP);
                                    end
                                    if (we) begin
                                        stored_next = idx + 7'd1;
                                    end
                                end
                                if ({1'b0, p} == {1'b0, crc_len}) begin
                                    fcrc_next = {fcrc_reg[15:8], b};
                                end else if ({1'b0, p} == {1'b0, crc_len} + 10'd1) begin
                                    fcrc_next = {b, fcrc_reg[7:0]};
                                end
                                pos_next = p1[8:0];
                                if (p1 >= total) begin
                                    phase_next = PH_IDLE;
                                    if (rd && bc_eff == 8'd0) begin
                                        pst_next = ST_BAD_LENGTH;
                                        cnt_next = '0;
                                        seq_next = SEQ_RESULT;
                                    end else if (crc_reg != fcrc_next) begin
                                        pst_next = ST_CRC_ERROR;
                                        cnt_next = '0;
                                        seq_next = SEQ_RESULT;
                                    end else begin
                                        pst_next = ST_OK;
                                        if (!rd) begin
                                            cnt_next = '0;
                                        end else if (coil) begin
                                            cnt_next = 8'(({1'b0, bc_eff} + 9'd1) >> 1);
                                        end else begin
                                            cnt_next = bc_eff >> 1;
                                        end
                                        n_full = (stored_next > 7'(MAX_RESULTS))
                                                 ? 7'(MAX_RESULTS) : stored_next;
                                        n_next = n_full[5:0];
                                        k_next = '0;
                                        seq_next = (n_full == 7'd0) ? SEQ_RESULT : SEQ_EMIT_RD;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            SEQ_CRC: begin
                // one polynomial step a cycle
                crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    seq_next = SEQ_IDLE;
                end
            end
            SEQ_RESULT: begin
                if (out_free) begin
                    out_next = '{status: pst_reg, data_word: 16'd0, word_index: 6'd0,
                                 word_count: cnt_reg, last: 1'b1};
                    mv_next  = 1'b1;
                    seq_next = SEQ_IDLE;
                end
            end
            SEQ_EMIT_RD: begin
                seq_next = SEQ_EMIT_PUT;
            end
            SEQ_EMIT_PUT: begin
                if (out_free) begin
                    out_next = '{status: ST_OK, data_word: rdata_reg, word_index: k_reg,
                                 word_count: cnt_reg, last: (k_reg + 6'd1 == n_reg)};
                    mv_next  = 1'b1;
                    if (k_reg + 6'd1 == n_reg) begin
                        seq_next = SEQ_IDLE;
                    end else begin
                        k_next   = k_reg + 6'd1;
                        seq_next = SEQ_EMIT_RD;
                    end
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

endmodule

FILE: test/testbench.sv
// self-checking testbench for the modbus rtu response checker
module testbench;
    import mrrc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    modbus_rtu_response_checker u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    localparam int CAPACITY = 32;
    localparam int CYCLE_LIMIT = 1000000;

    // shadow registers and reply state
    logic [7:0]  sh_addr;
    logic [4:0]  sh_func;
    logic [15:0] sh_hdr_to;
    logic [15:0] sh_body_to;
    phase_t      rp_phase;
    logic [8:0]  rp_pos;
    logic [15:0] rp_crc;
    logic [7:0]  rp_count;
    logic [7:0]  rp_held;
    logic [15:0] rp_words [CAPACITY];
    int          rp_stored;
    logic [15:0] rp_ticks;
    logic        rp_mismatch;
    logic [15:0] rp_frame_crc;

    out_item_t reply_queue[$];
    int  mismatches;
    int  results_seen;
    int  beats_sent;
    int  cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;

    function automatic bit fn_ok(logic [4:0] f);
        return (f >= 1 && f <= 6) || f == 15 || f == 16;
    endfunction

    function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
        c ^= {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic out_item_t mk(logic [2:0] st, logic [15:0] w, int idx, int cnt,
                                     bit lst);
        out_item_t r;
        r.status = st;
        r.data_word = w;
        r.word_index = idx[5:0];
        r.word_count = cnt[7:0];
        r.last = lst;
        return r;
    endfunction

    task automatic reply_fail(logic [2:0] st);
        rp_phase = PH_IDLE;
        reply_queue.push_back(mk(st, 16'h0, 0, 0, 1'b1));
    endtask

    task automatic reply_finish();
        bit rd;
        int cnt;
        int n;
        rd = sh_func >= 1 && sh_func <= 4;
        cnt = 0;
        if (rd && rp_count == 0) begin
            reply_fail(ST_BAD_LENGTH);
            return;
        end
        if (rp_crc != rp_frame_crc) begin
            reply_fail(ST_CRC_ERROR);
            return;
        end
        rp_phase = PH_IDLE;
        if (rd)
            cnt = (sh_func <= 2) ? (rp_count + 1) / 2 : rp_count / 2;
        n = rp_stored > MAX_RESULTS ? MAX_RESULTS : rp_stored;
        if (n == 0)
            reply_queue.push_back(mk(ST_OK, 16'h0, 0, cnt, 1'b1));
        for (int k = 0; k < n; k++)
            reply_queue.push_back(mk(ST_OK, rp_words[k], k, cnt, k + 1 == n));
    endtask

    task automatic keep_word(int idx, logic [15:0] w);
        if (idx < CAPACITY) begin
            rp_words[idx] = w;
            rp_stored = idx + 1;
        end
    endtask

    task automatic predict_body(logic [7:0] b);
        bit rd;
        int p;
        int crc_len;
        int d;
        rd = sh_func >= 1 && sh_func <= 4;
        p = rp_pos;
        if (rd && p == 2) begin
            rp_count = b;
            if (5 + b > RX_BUFFER_BYTES) begin
                reply_fail(ST_BAD_LENGTH);
                return;
            end
        end
        crc_len = rd ? 3 + rp_count : 6;
        if (p < crc_len)
            rp_crc = crc_byte(rp_crc, b);
        if (rd && p >= 3 && p < crc_len) begin
            d = p - 3;
            if (d % 2 == 0) begin
                rp_held = b;
                if (sh_func <= 2 && d + 1 == rp_count)
                    keep_word(d / 2, {8'h00, b});
            end else begin
                keep_word(d / 2, sh_func <= 2 ? {b, rp_held} : {rp_held, b});
            end
        end
        if (p == crc_len)
            rp_frame_crc[7:0] = b;
        else if (p == crc_len + 1)
            rp_frame_crc[15:8] = b;
        rp_pos = 9'(p + 1);
        if (p + 1 >= crc_len + 2)
            reply_finish();
    endtask

    task automatic predict_reply(in_item_t it);
        if (it.func == FUNC_START) begin
            rp_pos = 0;
            rp_crc = CRC_INIT;
            rp_count = 0;
            rp_held = 0;
            rp_stored = 0;
            rp_ticks = 0;
            rp_mismatch = 0;
            rp_frame_crc = 0;
            if (!fn_ok(sh_func))
                reply_fail(ST_UNSUPPORTED);
            else
                rp_phase = PH_HEADER;
            return;
        end
        if (it.func == 2'd3 || rp_phase == PH_IDLE)
            return;
        if (!fn_ok(sh_func)) begin
            reply_fail(ST_UNSUPPORTED);
            return;
        end
        if (it.func == FUNC_TICK) begin
            if (rp_phase == PH_HEADER ? rp_ticks >= sh_hdr_to
                    : (rp_ticks > sh_body_to || rp_ticks == 16'hFFFF)) begin
                reply_fail(ST_TIMEOUT);
                return;
            end
            rp_ticks++;
            return;
        end
        if (rp_phase == PH_HEADER) begin
            if (rp_mismatch)
                return;
            if (rp_pos == 0) begin
                if (it.rx_byte != sh_addr) begin
                    rp_mismatch = 1;
                    return;
                end
                rp_crc = crc_byte(rp_crc, it.rx_byte);
                rp_pos = 1;
            end else begin
                if (it.rx_byte != {3'b000, sh_func}) begin
                    rp_mismatch = 1;
                    return;
                end
                rp_crc = crc_byte(rp_crc, it.rx_byte);
                rp_pos = 2;
                rp_phase = PH_BODY;
                rp_ticks = 0;
            end
            return;
        end
        predict_body(it.rx_byte);
    endtask

    // sender: one beat, random idle beforehand; valid drops only when idling
    task automatic send_beat(logic [1:0] f, logic [7:0] b);
        in_item_t it;
        it.func = f;
        it.rx_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_reply(it);
        beats_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SLAVE_ADDRESS:     sh_addr = val[7:0];
            REG_EXPECTED_FUNCTION: sh_func = val[4:0];
            REG_HEADER_TIMEOUT:    sh_hdr_to = val;
            default:               sh_body_to = val;
        endcase
    endtask

    // well-formed reply with optional crc corruption
    task automatic send_frame(int nbytes, bit bad_crc);
        logic [7:0] fr [$];
        logic [15:0] c;
        bit rd;
        rd = sh_func >= 1 && sh_func <= 4;
        fr.push_back(sh_addr);
        fr.push_back({3'b000, sh_func});
        if (rd) begin
            fr.push_back(nbytes[7:0]);
            for (int i = 0; i < nbytes; i++)
                fr.push_back(8'($urandom_range(255)));
        end else begin
            for (int i = 0; i < 4; i++)
                fr.push_back(8'($urandom_range(255)));
        end
        c = CRC_INIT;
        foreach (fr[i])
            c = crc_byte(c, fr[i]);
        if (bad_crc)
            c ^= 16'h0001 << $urandom_range(15);
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        send_beat(FUNC_START, 8'($urandom_range(255)));
        foreach (fr[i]) begin
            if ($urandom_range(9) == 0)
                send_beat(FUNC_TICK, 8'($urandom_range(255)));
            send_beat(FUNC_BYTE, fr[i]);
        end
    endtask

    task automatic test_directed();
        write_reg(REG_SLAVE_ADDRESS, 16'd255);
        write_reg(REG_EXPECTED_FUNCTION, 16'd1);
        send_frame(3, 0);      // odd coil byte padded
        write_reg(REG_EXPECTED_FUNCTION, 16'd3);
        send_frame(5, 0);      // odd register byte dropped
        send_frame(0, 0);      // zero byte count
        send_frame(4, 1);
        write_reg(REG_EXPECTED_FUNCTION, 16'd16);
        send_frame(0, 0);
        write_reg(REG_EXPECTED_FUNCTION, 16'd9);
        send_beat(FUNC_START, 8'h00);
        write_reg(REG_EXPECTED_FUNCTION, 16'd5);
        write_reg(REG_SLAVE_ADDRESS, 16'd0);
        write_reg(REG_HEADER_TIMEOUT, 16'd0);
        send_beat(FUNC_START, 8'hFF);
        send_beat(FUNC_TICK, 8'h00);
        write_reg(REG_HEADER_TIMEOUT, 16'd2);
        send_beat(FUNC_START, 8'h00);
        send_beat(FUNC_BYTE, 8'h00);
        send_beat(FUNC_BYTE, 8'h05);
        write_reg(REG_BODY_TIMEOUT, 16'd0);
        send_beat(FUNC_TICK, 8'h00);
        send_beat(FUNC_TICK, 8'h00);
        send_beat(2'd3, 8'hAA);
        send_beat(FUNC_TICK, 8'h00);
        write_reg(REG_EXPECTED_FUNCTION, 16'd4);
        write_reg(REG_HEADER_TIMEOUT, 16'd65535);
        write_reg(REG_BODY_TIMEOUT, 16'd65535);
        send_beat(FUNC_START, 8'h00);
        send_beat(FUNC_BYTE, 8'h00);
        send_beat(FUNC_BYTE, 8'h04);
        send_beat(FUNC_BYTE, 8'd252);   // oversize frame
    endtask

    task automatic test_large_reply();
        write_reg(REG_SLAVE_ADDRESS, 16'd1);
        write_reg(REG_EXPECTED_FUNCTION, 16'd3);
        hold_off = 1'b1;
        send_frame(66, 0);     // more words than the store holds
        // keep offering beats while the results back up
        repeat (4) send_beat(FUNC_TICK, 8'h00);
    endtask

    task automatic test_random();
        int fns [8] = '{1, 2, 3, 4, 5, 6, 15, 16};
        int budget;
        budget = beats_sent + 8;
        while (beats_sent < budget) begin
            if ($urandom_range(5) == 0) begin
                write_reg(REG_SLAVE_ADDRESS, 16'($urandom_range(255)));
                write_reg(REG_EXPECTED_FUNCTION, 16'(fns[$urandom_range(7)]));
                write_reg(REG_HEADER_TIMEOUT, 16'($urandom_range(8)));
                write_reg(REG_BODY_TIMEOUT, $urandom_range(1) ? 16'd65535
                                                               : 16'($urandom_range(20)));
            end
            case ($urandom_range(9))
                0: send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
                1: begin
                    send_beat(FUNC_START, 8'h00);
                    repeat ($urandom_range(6))
                        send_beat(2'($urandom_range(1, 2)), 8'($urandom_range(255)));
                end
                2: send_frame($urandom_range(8), 1);
                default: send_frame($urandom_range(12), 0);
            endcase
        end
    endtask

    // receiver: random stall, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    initial begin
        int n;
        wait (hold_off);
        n = 0;
        while (n < 2000) begin
            @(posedge aclk);
            n++;
        end
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (reply_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", m_data);
            end else begin
                want = reply_queue.pop_front();
                if (want.status !== m_data.status || want.data_word !== m_data.data_word
                        || want.word_index !== m_data.word_index
                        || want.word_count !== m_data.word_count
                        || want.last !== m_data.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_SLAVE_ADDRESS;
        cfg_data = '0;
        m_ready = 1'b0;
        hold_off = 1'b0;
        mismatches = 0;
        results_seen = 0;
        beats_sent = 0;
        cycles = 0;
        sh_addr = 8'd1;
        sh_func = 5'd3;
        sh_hdr_to = 16'd100;
        sh_body_to = 16'd100;
        rp_phase = PH_IDLE;
        send_idle_pct = 7;
        recv_idle_pct = 60;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_large_reply();
        test_random();
        send_idle_pct = 60;
        recv_idle_pct = 7;
        test_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random();
        settle();
        $display("%0d input beats sent, %0d results checked", beats_sent, results_seen);
        $display("covered coil/register reads, writes, crc, timeout and length errors");
        if (mismatches == 0 && reply_queue.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench failed");
        end
        $finish;
    end
endmodule
